>>> hw/rtl/mcst_pkg.sv
// Shared types, codes and constants for the timer slot table.
// No dependencies; every other file imports this package.
package mcst_pkg;

    localparam int SLOTS_DEF       = 16;
    localparam int PERIOD_BITS_DEF = 24;
    localparam int MAX_FIRES       = 16;
    localparam int NOW_BITS        = 32;
    localparam int SLOT_BITS       = 4;
    localparam int FIELD_BITS      = 24;
    localparam int FRAC_BITS       = 16;
    localparam int FRAC_W          = FRAC_BITS + 1;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};
    localparam logic [FRAC_W-1:0]     FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_SET,
        ACT_CLR,
        ACT_QRY
    } t_action;

    typedef enum logic [1:0] {
        KIND_FIRE,
        KIND_SET,
        KIND_CLR,
        KIND_QRY
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_ABSENT,
        STAT_FULL
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SET,
        ST_CLR,
        ST_QRD,
        ST_QCHK,
        ST_QDIV,
        ST_QOUT
    } t_state;

    typedef struct packed {
        t_action                 action;
        logic [SLOT_BITS-1:0]    slot;
        logic [FIELD_BITS-1:0]   period_ticks;
        logic                    repeating;
    } t_cmd;

    typedef struct packed {
        t_kind                   kind;
        t_status                 status;
        logic [SLOT_BITS-1:0]    slot_out;
        logic [FIELD_BITS-1:0]   elapsed_ticks;
        logic [FIELD_BITS-1:0]   remaining_ticks;
        logic [FIELD_BITS-1:0]   period_out;
        logic [FRAC_W-1:0]       fraction;
        logic                    last;
    } t_res;

endpackage

>>> hw/rtl/mcst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on mcst_pkg for default sizes only.
module mcst_ram import mcst_pkg::*; #(
    parameter int WIDTH = 1 + PERIOD_BITS_DEF + NOW_BITS,
    parameter int DEPTH = SLOTS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mcst_div.sv
// Restoring serial divider: one quotient bit per cycle.
// Gives floor(num * 2^FRAC_BITS / den) for num < den. Depends on mcst_pkg.
module mcst_div import mcst_pkg::*; #(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PERIOD_BITS-1:0] i_num,
    input  logic [PERIOD_BITS-1:0] i_den,
    output logic                   o_done,
    output logic [FRAC_BITS-1:0]   o_quo
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [PERIOD_BITS-1:0] r_rem, n_rem;
    logic [PERIOD_BITS-1:0] r_den, n_den;
    logic [FRAC_BITS-1:0]   r_quo, n_quo;

    logic [PERIOD_BITS:0]   trial;
    logic [PERIOD_BITS:0]   diff;
    logic                   fits;

    assign trial = {r_rem, 1'b0};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(FRAC_BITS);
            n_rem  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
            n_quo = {r_quo[FRAC_BITS-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> hw/rtl/multi_channel_software_timer_table.sv
// Timer slot table top level: sequencer, live bits, tick counter, result register.
// Depends on mcst_pkg, mcst_ram (slot repeat/period/start store), mcst_div (fraction).
//
//   channel   direction  handshake                  payload
//   command   in         start high, busy low       i_cmd (t_cmd)
//   result    out        o_res_vld, one cycle       o_res (t_res)
//
// Tick: one slot read from the slot store per cycle.
// Set steps through the live bits to the first free slot.
// Query sends the fraction through the serial divider only while the period is not reached.
// Synchronous active-low reset clears the live bits and the tick counter at once.
// Results cannot be stalled; each shows for one cycle, a new command may start while a last beat shows.
module multi_channel_software_timer_table import mcst_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_res_vld,
    output t_res o_res
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW    = 1 + PERIOD_BITS + NOW_BITS;
    localparam int CW    = $clog2(MAX_FIRES + 1);

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [NOW_BITS-1:0]    r_now, n_now;
    logic [SLOTS-1:0]       r_live, n_live;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_issue, n_issue;
    logic                   r_chk, n_chk;
    logic [IW-1:0]          r_chk_idx, n_chk_idx;
    logic                   r_pend, n_pend;
    logic [IW-1:0]          r_pend_slot, n_pend_slot;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [NOW_BITS-1:0]    r_el, n_el;
    logic [PERIOD_BITS-1:0] r_per, n_per;
    logic [FRAC_W-1:0]      r_frac, n_frac;
    logic                   r_res_vld, n_res_vld;
    t_res                   r_res, n_res;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [RW-1:0]          ram_wdata;
    logic [IW-1:0]          ram_raddr;
    logic [RW-1:0]          ram_rdata;

    logic                   rd_rep;
    logic [PERIOD_BITS-1:0] rd_per;
    logic [NOW_BITS-1:0]    rd_start;
    logic [NOW_BITS-1:0]    ram_el;
    logic                   el_reached;
    logic                   chk_due;
    logic [IW-1:0]          cmd_idx;
    logic                   slot_bad;
    logic                   idx_last;
    logic                   div_start;
    logic                   div_done;
    logic [FRAC_BITS-1:0]   div_quo;
    logic [NOW_BITS-1:0]    per32;
    logic [NOW_BITS-1:0]    rem32;

    function automatic t_res mk_res(input t_kind kind, input t_status status,
                                    input logic [SLOT_BITS-1:0] slot, input logic last);
        t_res res;
        res          = '0;
        res.kind     = kind;
        res.status   = status;
        res.slot_out = slot;
        res.last     = last;
        return res;
    endfunction

    function automatic logic [FIELD_BITS-1:0] sat_field(input logic [NOW_BITS-1:0] v);
        return (v > NOW_BITS'(FIELD_MAX)) ? FIELD_MAX : v[FIELD_BITS-1:0];
    endfunction

    mcst_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mcst_div #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (PERIOD_BITS'(ram_el)),
        .i_den   (rd_per),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign rd_rep     = ram_rdata[RW-1];
    assign rd_per     = ram_rdata[NOW_BITS +: PERIOD_BITS];
    assign rd_start   = ram_rdata[NOW_BITS-1:0];
    assign ram_el     = r_now - rd_start;
    assign el_reached = ram_el >= NOW_BITS'(rd_per);
    assign chk_due    = r_chk && r_live[r_chk_idx] && el_reached
                        && (r_cnt < CW'(MAX_FIRES));
    assign cmd_idx    = IW'(r_cmd.slot);
    assign slot_bad   = (32'(r_cmd.slot) >= 32'(SLOTS)) || !r_live[cmd_idx];
    assign idx_last   = r_idx == IW'(SLOTS - 1);
    assign per32      = NOW_BITS'(r_per);
    assign rem32      = (r_el >= per32) ? '0 : (per32 - r_el);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd.action)
                        ACT_TICK: n_state = ST_TICK;
                        ACT_SET:  n_state = ST_SET;
                        ACT_CLR:  n_state = ST_CLR;
                        ACT_QRY:  n_state = ST_QRD;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                if (!r_issue && !r_chk) n_state = ST_IDLE;
            end
            ST_SET: begin
                if (!r_live[r_idx] || idx_last) n_state = ST_IDLE;
            end
            ST_CLR:  n_state = ST_IDLE;
            ST_QRD:  n_state = slot_bad ? ST_IDLE : ST_QCHK;
            ST_QCHK: n_state = el_reached ? ST_QOUT : ST_QDIV;
            ST_QDIV: begin
                if (div_done) n_state = ST_QOUT;
            end
            ST_QOUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: slot store port, divider start, result beat
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = {rd_rep, rd_per, r_now};
        ram_raddr = r_idx;
        div_start = 1'b0;
        n_res_vld = 1'b0;
        n_res     = '0;
        case (r_state)
            ST_TICK: begin
                if (chk_due) begin
                    // restart a repeating slot at the current tick
                    ram_we = rd_rep;
                    if (r_pend) begin
                        n_res_vld = 1'b1;
                        n_res = mk_res(KIND_FIRE, STAT_OK, SLOT_BITS'(r_pend_slot), 1'b0);
                    end
                end else if (!r_issue && !r_chk && r_pend) begin
                    n_res_vld = 1'b1;
                    n_res = mk_res(KIND_FIRE, STAT_OK, SLOT_BITS'(r_pend_slot), 1'b1);
                end
            end
            ST_SET: begin
                if (!r_live[r_idx]) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx;
                    ram_wdata = {r_cmd.repeating, PERIOD_BITS'(r_cmd.period_ticks), r_now};
                    n_res_vld = 1'b1;
                    n_res = mk_res(KIND_SET, STAT_OK, SLOT_BITS'(r_idx), 1'b1);
                end else if (idx_last) begin
                    n_res_vld = 1'b1;
                    n_res = mk_res(KIND_SET, STAT_FULL, '0, 1'b1);
                end
            end
            ST_CLR: begin
                n_res_vld = 1'b1;
                n_res = mk_res(KIND_CLR, slot_bad ? STAT_ABSENT : STAT_OK, r_cmd.slot, 1'b1);
            end
            ST_QRD: begin
                ram_raddr = cmd_idx;
                if (slot_bad) begin
                    n_res_vld = 1'b1;
                    n_res = mk_res(KIND_QRY, STAT_ABSENT, r_cmd.slot, 1'b1);
                end
            end
            ST_QCHK: begin
                div_start = !el_reached;
            end
            ST_QOUT: begin
                n_res_vld             = 1'b1;
                n_res                 = mk_res(KIND_QRY, STAT_OK, r_cmd.slot, 1'b1);
                n_res.elapsed_ticks   = sat_field(r_el);
                n_res.remaining_ticks = sat_field(rem32);
                n_res.period_out      = sat_field(per32);
                n_res.fraction        = r_frac;
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        n_cmd       = r_cmd;
        n_now       = r_now;
        n_live      = r_live;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_cnt       = r_cnt;
        n_el        = r_el;
        n_per       = r_per;
        n_frac      = r_frac;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_issue = i_cmd.action == ACT_TICK;
                    n_chk   = 1'b0;
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                    if (i_cmd.action == ACT_TICK) n_now = r_now + 1'b1;
                end
            end
            ST_TICK: begin
                // issue one slot read per cycle, check it the cycle after
                n_chk     = r_issue;
                n_chk_idx = r_idx;
                if (r_issue) begin
                    if (idx_last) n_issue = 1'b0;
                    else          n_idx   = r_idx + 1'b1;
                end
                if (chk_due) begin
                    n_cnt       = r_cnt + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_slot = r_chk_idx;
                    if (!rd_rep) n_live[r_chk_idx] = 1'b0;
                end
            end
            ST_SET: begin
                if (!r_live[r_idx]) n_live[r_idx] = 1'b1;
                else if (!idx_last) n_idx = r_idx + 1'b1;
            end
            ST_CLR: begin
                if (!slot_bad) n_live[cmd_idx] = 1'b0;
            end
            ST_QCHK: begin
                n_el  = ram_el;
                n_per = rd_per;
                if (el_reached) n_frac = FRAC_ONE;
            end
            ST_QDIV: begin
                if (div_done) n_frac = {1'b0, div_quo};
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_now     <= '0;
            r_live    <= '0;
            r_idx     <= '0;
            r_issue   <= 1'b0;
            r_chk     <= 1'b0;
            r_pend    <= 1'b0;
            r_cnt     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_live    <= n_live;
            r_idx     <= n_idx;
            r_issue   <= n_issue;
            r_chk     <= n_chk;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
            r_res_vld <= n_res_vld;
        end
        r_cmd       <= n_cmd;
        r_chk_idx   <= n_chk_idx;
        r_pend_slot <= n_pend_slot;
        r_el        <= n_el;
        r_per       <= n_per;
        r_frac      <= n_frac;
        r_res       <= n_res;
    end

    assign busy      = (r_state != ST_IDLE) || !i_rst_n;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule

>>> hw/rtl/mcst_chk.sv
// Port-level checker for the timer slot table, bound to the top level.
// Depends on mcst_pkg for the command and result types and codes.
module mcst_chk import mcst_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_cmd i_cmd,
    input logic o_res_vld,
    input t_res o_res
);

    // a result beat only follows a cycle of work
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> $past(busy))
        else $error("result beat without preceding work");

    // only fire beats may leave the burst open
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.kind != KIND_FIRE) |-> o_res.last)
        else $error("reply beat without last");

    a_full_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && o_res.status == STAT_FULL) |->
            (o_res.kind == KIND_SET && o_res.slot_out == '0))
        else $error("table full reply malformed");

    // clear answers with a last clear beat, through the clear state and the result register
    a_clear_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.action == ACT_CLR) |->
            ##2 (o_res_vld && o_res.kind == KIND_CLR && o_res.last))
        else $error("clear reply missing");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command beat did not raise busy");

endmodule

bind multi_channel_software_timer_table mcst_chk u_mcst_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_cmd     (i_cmd),
    .o_res_vld (o_res_vld),
    .o_res     (o_res)
);
